// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the framer RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define FQRF_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// cons must hold in the same cycle whenever ante holds
`define FQRF_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante holds
`define FQRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/fqrf_pkg.sv =====
// Package for the FASTQ record framer: payload structs, parse phases,
// character codes and default widths. No dependencies.
package fqrf_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int FIELD_BITS = 32;

   localparam logic [7:0] CH_AT   = 8'h40;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_NL   = 8'h0A;

   typedef enum logic [2:0] {
      PH_SEARCH   = 3'd0,
      PH_HEADER   = 3'd1,
      PH_SEQ      = 3'd2,
      PH_PLUSCHK  = 3'd3,
      PH_PLUSLINE = 3'd4,
      PH_QUAL     = 3'd5,
      PH_QEND     = 3'd6
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_in_file;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] header_start;
      logic [FIELD_BITS-1:0] header_length;
      logic [FIELD_BITS-1:0] sequence_start;
      logic [FIELD_BITS-1:0] sequence_length;
      logic [FIELD_BITS-1:0] quality_start;
   } rsp_type;

endpackage

// ===== hw/rtl/fastq_record_framer_top.sv =====
// FASTQ record framer, top level: byte input channel, record output channel.
// Depends on fqrf_pkg, fqrf_parser and fqrf_out_stage.
//
// Usage:
//   req_ channel carries one file byte per transaction with a flag on the
//   final byte of a file. rsp_ channel carries one transaction per complete
//   FASTQ record: header, sequence and quality offsets plus header and
//   sequence lengths (quality length equals sequence length).
//   Throughput: one byte per cycle while req_ready is high; the parse state
//   advances in the cycle the byte is accepted.
//   A completed record is registered in the output register, or in the skid
//   entry while the output is stalled, when its closing newline is accepted.
//   Stall: the output register plus one skid entry absorb results; req_ready
//   drops only while both hold a result the receiver has not taken.
//   Reset: synchronous; parser returns to searching for '@' with offset 0,
//   output stage empty. After a byte flagged last_in_file the parser state
//   and offset also return to zero.
//   Offsets saturate at 2^OFFSET_BITS-1 and are presented as 32-bit fields.

module fastq_record_framer_top #(
   parameter int OFFSET_BITS = fqrf_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fqrf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fqrf_pkg::rsp_type rsp_data
);
   import fqrf_pkg::*;

   logic    accept;
   logic    result_valid;
   rsp_type result;
   logic    space;

   assign req_ready = space;
   assign accept    = req_valid & space;

   fqrf_parser #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_data     (req_data),
      .result_valid (result_valid),
      .result       (result)
   );

   fqrf_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/fqrf_parser.sv =====
// Per-byte parse state machine of the FASTQ record framer.
// Depends on fqrf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fqrf_parser #(
   parameter int OFFSET_BITS = fqrf_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  fqrf_pkg::req_type req_data,
   output logic             result_valid,
   output fqrf_pkg::rsp_type result
);
   import fqrf_pkg::*;

   typedef logic [OFFSET_BITS-1:0] off_type;
   localparam off_type OFF_MAX = '1;

   function automatic off_type sat_inc(input off_type v);
      return (v == OFF_MAX) ? v : v + off_type'(1);
   endfunction

   function automatic off_type span(input off_type end_v, input off_type start_v);
      return (end_v >= start_v) ? end_v - start_v : '0;
   endfunction

   phase_type phase_ff, phase_in;
   off_type   byte_offset_ff, byte_offset_in;
   off_type   hstart_ff, hstart_in;
   off_type   hlen_ff, hlen_in;
   off_type   sstart_ff, sstart_in;
   off_type   slen_ff, slen_in;
   off_type   qstart_ff, qstart_in;
   off_type   qleft_ff, qleft_in;
   off_type   off_inc;
   off_type   qdec;
   logic      emit;
   logic      is_nl;
   logic      is_at;

   always_comb begin
      off_inc  = sat_inc(byte_offset_ff);
      is_nl    = (req_data.data_byte == CH_NL);
      is_at    = (req_data.data_byte == CH_AT);
      qdec     = (qleft_ff != '0) ? qleft_ff - off_type'(1) : qleft_ff;
      phase_in  = phase_ff;
      hstart_in = hstart_ff;
      hlen_in   = hlen_ff;
      sstart_in = sstart_ff;
      slen_in   = slen_ff;
      qstart_in = qstart_ff;
      qleft_in  = qleft_ff;
      emit      = 1'b0;
      byte_offset_in = off_inc;

      case (phase_ff)
         PH_HEADER: begin
            if (is_nl) begin
               hlen_in   = span(byte_offset_ff, hstart_ff);
               sstart_in = off_inc;
               phase_in  = PH_SEQ;
            end
         end
         PH_SEQ: begin
            if (is_nl) begin
               slen_in  = span(byte_offset_ff, sstart_ff);
               phase_in = PH_PLUSCHK;
            end
         end
         PH_PLUSCHK: begin
            if (req_data.data_byte == CH_PLUS) begin
               phase_in = PH_PLUSLINE;
            end else if (is_at) begin
               hstart_in = off_inc;
               phase_in  = PH_HEADER;
            end else begin
               phase_in = PH_SEARCH;
            end
         end
         PH_PLUSLINE: begin
            if (is_nl) begin
               qstart_in = off_inc;
               qleft_in  = slen_ff;
               phase_in  = (slen_ff == '0) ? PH_QEND : PH_QUAL;
            end
         end
         PH_QUAL: begin
            qleft_in = qdec;
            if (qdec == '0) begin
               phase_in = PH_QEND;
            end
         end
         PH_QEND: begin
            if (is_nl) begin
               emit     = 1'b1;
               phase_in = PH_SEARCH;
            end else if (is_at) begin
               hstart_in = off_inc;
               phase_in  = PH_HEADER;
            end else begin
               phase_in = PH_SEARCH;
            end
         end
         default: begin
            if (is_at) begin
               hstart_in = off_inc;
               phase_in  = PH_HEADER;
            end else begin
               phase_in = PH_SEARCH;
            end
         end
      endcase

      // end of file: drop any partial record and restart offsets
      if (req_data.last_in_file) begin
         phase_in       = PH_SEARCH;
         byte_offset_in = '0;
         hstart_in      = '0;
         hlen_in        = '0;
         sstart_in      = '0;
         slen_in        = '0;
         qstart_in      = '0;
         qleft_in       = '0;
      end

      result_valid           = accept & emit;
      result.header_start    = FIELD_BITS'(hstart_ff);
      result.header_length   = FIELD_BITS'(hlen_ff);
      result.sequence_start  = FIELD_BITS'(sstart_ff);
      result.sequence_length = FIELD_BITS'(slen_ff);
      result.quality_start   = FIELD_BITS'(qstart_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SEARCH;
         byte_offset_ff <= '0;
         hstart_ff      <= '0;
         hlen_ff        <= '0;
         sstart_ff      <= '0;
         slen_ff        <= '0;
         qstart_ff      <= '0;
         qleft_ff       <= '0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         byte_offset_ff <= byte_offset_in;
         hstart_ff      <= hstart_in;
         hlen_ff        <= hlen_in;
         sstart_ff      <= sstart_in;
         slen_ff        <= slen_in;
         qstart_ff      <= qstart_in;
         qleft_ff       <= qleft_in;
      end
   end

   `FQRF_ASSERT_IMPLY(a_qual_nonzero, phase_ff == PH_QUAL, qleft_ff != '0, "quality count empty in QUAL")
   `FQRF_ASSERT_IMPLY(a_qual_bound, phase_ff == PH_QUAL, qleft_ff <= slen_ff, "quality count above sequence length")
   `FQRF_ASSERT_NEXT(a_eof_clear, accept && req_data.last_in_file, (phase_ff == PH_SEARCH) && (byte_offset_ff == '0), "state not cleared after last byte")

endmodule

// ===== hw/rtl/fqrf_out_stage.sv =====
// Result register with skid entry for the FASTQ record framer.
// Depends on fqrf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fqrf_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fqrf_pkg::rsp_type push_data,
   output logic              space,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fqrf_pkg::rsp_type rsp_data
);
   import fqrf_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   always_comb begin
      pop           = rsp_valid_ff & rsp_ready;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff || pop) begin
            rsp_data_in  = push_data;
            rsp_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign space     = ~skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FQRF_ASSERT_IMPLY(a_skid_behind_rsp, skid_valid_ff, rsp_valid_ff, "skid entry held with empty result register")
   `FQRF_ASSERT_NEXT(a_skid_fill, !skid_valid_ff && push && rsp_valid_ff && !rsp_ready, skid_valid_ff, "result lost on stalled output")
   `FQRF_ASSERT_NEXT(a_skid_hold, skid_valid_ff && !pop, skid_valid_ff && $stable(skid_data_ff), "skid entry dropped before output moved")

endmodule

// ===== bench/fqrf_record_checker.sv =====
// Scoreboard for the FASTQ record framer: watches both channels, predicts
// the record transactions from the accepted bytes and compares them in order.
// Depends on fqrf_pkg.
module fqrf_record_checker
   import fqrf_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      pending
);

   typedef logic [OFFSET_BITS-1:0] offset_type;

   phase_type  phase;
   offset_type byte_pos, hdr_start, hdr_len, seq_start, seq_len, qual_start, qual_left;
   rsp_type    records_due[$];
   int         fail_total = 0;

   function automatic offset_type bump(offset_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic offset_type distance(offset_type stop, offset_type start);
      return (stop >= start) ? offset_type'(stop - start) : '0;
   endfunction

   task automatic clear_parser();
      phase      = PH_SEARCH;
      byte_pos   = '0;
      hdr_start  = '0;
      hdr_len    = '0;
      seq_start  = '0;
      seq_len    = '0;
      qual_start = '0;
      qual_left  = '0;
   endtask

   task automatic hunt_at(logic [7:0] b, offset_type off);
      if (b == CH_AT) begin
         hdr_start = bump(off);
         phase     = PH_HEADER;
      end else begin
         phase = PH_SEARCH;
      end
   endtask

   task automatic frame_byte(req_type t);
      offset_type off;
      rsp_type    rec;
      off = byte_pos;
      case (phase)
         PH_HEADER: begin
            if (t.data_byte == CH_NL) begin
               hdr_len   = distance(off, hdr_start);
               seq_start = bump(off);
               phase     = PH_SEQ;
            end
         end
         PH_SEQ: begin
            if (t.data_byte == CH_NL) begin
               seq_len = distance(off, seq_start);
               phase   = PH_PLUSCHK;
            end
         end
         PH_PLUSCHK: begin
            if (t.data_byte == CH_PLUS) begin
               phase = PH_PLUSLINE;
            end else begin
               hunt_at(t.data_byte, off);
            end
         end
         PH_PLUSLINE: begin
            if (t.data_byte == CH_NL) begin
               qual_start = bump(off);
               qual_left  = seq_len;
               phase      = (qual_left == 0) ? PH_QEND : PH_QUAL;
            end
         end
         PH_QUAL: begin
            if (qual_left > 0) begin
               qual_left = qual_left - 1'b1;
            end
            if (qual_left == 0) begin
               phase = PH_QEND;
            end
         end
         PH_QEND: begin
            if (t.data_byte == CH_NL) begin
               rec.header_start    = FIELD_BITS'(hdr_start);
               rec.header_length   = FIELD_BITS'(hdr_len);
               rec.sequence_start  = FIELD_BITS'(seq_start);
               rec.sequence_length = FIELD_BITS'(seq_len);
               rec.quality_start   = FIELD_BITS'(qual_start);
               records_due.push_back(rec);
               phase = PH_SEARCH;
            end else begin
               hunt_at(t.data_byte, off);
            end
         end
         default: begin
            hunt_at(t.data_byte, off);
         end
      endcase
      byte_pos = bump(off);
      if (t.last_in_file) begin
         clear_parser();
      end
   endtask

   task automatic check_field(input string name, input logic [FIELD_BITS-1:0] want,
                              input logic [FIELD_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         records_due.delete();
      end else begin
         if (req_valid && req_ready) begin
            frame_byte(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (records_due.size() == 0) begin
               $display("%0t: record mismatch, expected none, actual %p", $time, rsp_data);
               fail_total++;
            end else begin
               check_field("header_start", records_due[0].header_start,
                           rsp_data.header_start);
               check_field("header_length", records_due[0].header_length,
                           rsp_data.header_length);
               check_field("sequence_start", records_due[0].sequence_start,
                           rsp_data.sequence_start);
               check_field("sequence_length", records_due[0].sequence_length,
                           rsp_data.sequence_length);
               check_field("quality_start", records_due[0].quality_start,
                           rsp_data.quality_start);
               void'(records_due.pop_front());
            end
         end
      end
      mismatches <= fail_total;
      pending    <= records_due.size();
   end

endmodule

// ===== bench/tb_fastq_record_framer_top.sv =====
// Testbench top for fastq_record_framer_top: drives byte files with random
// idling, runs the response-side stalls and gives the verdict.
// Depends on fqrf_pkg, fqrf_record_checker and the framer RTL.
module tb_fastq_record_framer_top;
   import fqrf_pkg::*;

   // narrow offsets so that they are zero extended into the 32-bit fields
   localparam int OFFSET_BITS  = 16;
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_BYTES = 1200;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   bit         stall_on = 1'b0;
   int         mismatch_count;
   int         records_pending;
   int         quiet_cycles = 0;
   int         bytes_sent = 0;
   logic [7:0] file_bytes[$];

   fastq_record_framer_top #(.OFFSET_BITS(OFFSET_BITS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   fqrf_record_checker #(.OFFSET_BITS(OFFSET_BITS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatch_count),
      .pending    (records_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= (stall_on && $urandom_range(0, 99) < 16) ? 1'b0 : 1'b1;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [7:0] byte_except(logic [7:0] avoid);
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == avoid) ? (b ^ 8'h01) : b;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while (stall_on && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {b, is_last};
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) begin
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      end
      file_bytes.delete();
   endtask

   task automatic push_text(input string s);
      foreach (s[i]) begin
         file_bytes.push_back(s[i]);
      end
   endtask

   task automatic add_noise();
      repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // one record, well formed most of the time; flaws: no plus, bad quality
   // terminator, cut short
   task automatic add_record();
      int         flaw;
      int         slen;
      logic [7:0] rec[$];
      flaw = $urandom_range(0, 9);
      slen = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
      rec.push_back(CH_AT);
      repeat ($urandom_range(0, 8)) rec.push_back(byte_except(CH_NL));
      rec.push_back(CH_NL);
      repeat (slen) rec.push_back(byte_except(CH_NL));
      rec.push_back(CH_NL);
      rec.push_back((flaw == 0) ? byte_except(CH_PLUS) : CH_PLUS);
      repeat ($urandom_range(0, 3)) rec.push_back(byte_except(CH_NL));
      rec.push_back(CH_NL);
      repeat (slen) begin
         rec.push_back(($urandom_range(0, 7) == 0) ? CH_NL : 8'($urandom_range(0, 255)));
      end
      rec.push_back((flaw == 1) ? byte_except(CH_NL) : CH_NL);
      if (flaw == 2) begin
         repeat ($urandom_range(1, rec.size() - 1)) void'(rec.pop_back());
      end
      foreach (rec[i]) begin
         file_bytes.push_back(rec[i]);
      end
   endtask

   initial begin
      int start;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      stall_on = 1'b1;

      // empty header and sequence, last byte closes the record
      push_text("@\n\n+\n\n");
      send_file();
      // missing plus restarts at an at sign; newline used as quality byte
      push_text("@\nG\n@\nC\n+\n\n\n");
      send_file();
      // missing quality newline, extreme byte values
      push_text("@\nA\n+\n");
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'h58);
      file_bytes.push_back(8'h00);
      send_file();
      // file ends inside a record
      push_text("@\nA");
      send_file();

      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         stall_on = !(bytes_sent - start >= 400 && bytes_sent - start < 700);
         if ($urandom_range(0, 9) == 0) begin
            add_noise();
         end else begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 3) == 0) begin
                  add_noise();
               end
               add_record();
            end
         end
         send_file();
      end
      stall_on = 1'b1;

      req_valid <= 1'b0;
      while (records_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && records_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
